// File: sv/csss_pkg.sv
// ----------------------------------------------------------------------------
// csss_pkg
// Shared types, constants and helpers for the case-folded substring search.
// ----------------------------------------------------------------------------
package csss_pkg;

    // Longest pattern the window can hold
    localparam int PATTERN_MAX = 32;
    // Pattern bytes carried by the four configuration words
    localparam int REG_BYTES   = 32;
    localparam int WORD_BYTES  = 8;
    localparam int CFG_WORDS   = REG_BYTES / WORD_BYTES;
    localparam int LEN_REG_W   = 6;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 64;

    // Count width: must hold PATTERN_MAX and any raw length register value
    localparam int CNT_W = ($clog2(PATTERN_MAX + 1) > LEN_REG_W) ?
                           $clog2(PATTERN_MAX + 1) : LEN_REG_W;
    // Window / pattern index width
    localparam int IDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

    typedef logic [7:0]                       byte_t;
    typedef logic [CFG_DATA_W-1:0]            word_t;
    typedef logic [CNT_W-1:0]                 count_t;
    typedef logic [PATTERN_MAX-1:0][7:0]      window_t;
    typedef logic [REG_BYTES-1:0][7:0]        pat_store_t;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PAT_LO     = 3'd0,
        CFG_PAT_MID_LO = 3'd1,
        CFG_PAT_MID_HI = 3'd2,
        CFG_PAT_HI     = 3'd3,
        CFG_PAT_LEN    = 3'd4
    } cfg_index_t;

    // Input transfer payload
    typedef struct packed {
        logic  last_byte;
        logic  first_byte;
        byte_t data_byte;
    } byte_item_t;

    // Result transfer payload
    typedef struct packed {
        logic found;
        logic file_done;
    } verdict_t;

    // Control carried alongside the window stage
    typedef struct packed {
        logic valid;
        logic first_byte;
        logic last_byte;
    } stage_t;

    // Fold ASCII upper case to lower case
    function automatic byte_t fold(input byte_t b);
        if ((b >= 8'h41) && (b <= 8'h5A))
        begin
            return b + 8'h20;
        end
        return b;
    endfunction

    // Fold every byte of a configuration word
    function automatic word_t fold_word(input word_t w);
        word_t r;
        for (int i = 0; i < WORD_BYTES; i++)
        begin
            r[i*8 +: 8] = fold(w[i*8 +: 8]);
        end
        return r;
    endfunction

endpackage

// File: sv/csss_cfg.sv
// ----------------------------------------------------------------------------
// csss_cfg
// Pattern and length registers; pattern bytes are stored already folded.
// ----------------------------------------------------------------------------
module csss_cfg
    import csss_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  word_t                cfg_data,
    output window_t              pattern,
    output logic [LEN_REG_W-1:0] pattern_length
);

    pat_store_t           pattern_reg;
    pat_store_t           pattern_next;
    logic [LEN_REG_W-1:0] length_reg;
    logic [LEN_REG_W-1:0] length_next;

    // Register write decode; unknown indexes are dropped
    always_comb
    begin
        pattern_next = pattern_reg;
        length_next  = length_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_PAT_LO:
                begin
                    pattern_next[0*WORD_BYTES +: WORD_BYTES] = fold_word(cfg_data);
                end
                CFG_PAT_MID_LO:
                begin
                    pattern_next[1*WORD_BYTES +: WORD_BYTES] = fold_word(cfg_data);
                end
                CFG_PAT_MID_HI:
                begin
                    pattern_next[2*WORD_BYTES +: WORD_BYTES] = fold_word(cfg_data);
                end
                CFG_PAT_HI:
                begin
                    pattern_next[3*WORD_BYTES +: WORD_BYTES] = fold_word(cfg_data);
                end
                CFG_PAT_LEN:
                begin
                    length_next = cfg_data[LEN_REG_W-1:0];
                end
                default:
                begin
                    length_next = length_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_reg <= '0;
            length_reg  <= LEN_REG_W'(1);
        end
        else
        begin
            pattern_reg <= pattern_next;
            length_reg  <= length_next;
        end
    end

    // Bytes past the configured words read as zero
    always_comb
    begin
        for (int k = 0; k < PATTERN_MAX; k++)
        begin
            if (k < REG_BYTES)
            begin
                pattern[k] = pattern_reg[k];
            end
            else
            begin
                pattern[k] = '0;
            end
        end
    end

    assign pattern_length = length_reg;

endmodule

// File: sv/csss_window.sv
// ----------------------------------------------------------------------------
// csss_window
// Input stage: folded byte window, saturating byte count, stage control.
// ----------------------------------------------------------------------------
module csss_window
    import csss_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       advance,
    input  logic       take,
    input  byte_item_t item,
    output window_t    window,
    output count_t     bytes_seen,
    output stage_t     stage
);

    window_t window_reg;
    window_t window_next;
    count_t  seen_reg;
    count_t  seen_next;
    stage_t  stage_reg;
    stage_t  stage_next;

    // Shift in the new folded byte, newest at entry 0
    always_comb
    begin
        window_next = window_reg;
        seen_next   = seen_reg;
        if (take)
        begin
            for (int i = PATTERN_MAX - 1; i > 0; i--)
            begin
                window_next[i] = window_reg[i-1];
            end
            window_next[0] = fold(item.data_byte);
            // New file restarts the count with this byte
            if (item.first_byte)
            begin
                seen_next = count_t'(1);
            end
            else if (seen_reg < count_t'(PATTERN_MAX))
            begin
                seen_next = seen_reg + count_t'(1);
            end
        end
    end

    // Stage control follows the pipeline advance
    always_comb
    begin
        stage_next = stage_reg;
        if (advance)
        begin
            stage_next.valid      = take;
            stage_next.first_byte = item.first_byte;
            stage_next.last_byte  = item.last_byte;
        end
    end

    // Window holds payload only
    always_ff @(posedge clk)
    begin
        window_reg <= window_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg  <= '0;
            stage_reg <= '0;
        end
        else
        begin
            seen_reg  <= seen_next;
            stage_reg <= stage_next;
        end
    end

    assign window     = window_reg;
    assign bytes_seen = seen_reg;
    assign stage      = stage_reg;

endmodule

// File: sv/csss_match.sv
// ----------------------------------------------------------------------------
// csss_match
// Parallel compare of the window against the length-aligned pattern.
// ----------------------------------------------------------------------------
module csss_match
    import csss_pkg::*;
(
    input  window_t              window,
    input  window_t              pattern,
    input  logic [LEN_REG_W-1:0] pattern_length,
    input  count_t               bytes_seen,
    output logic                 match
);

    count_t                 len_wide;
    count_t                 len_eff;
    count_t                 pos;
    logic [PATTERN_MAX-1:0] lane_ok;

    // Clamp length to window size
    always_comb
    begin
        len_wide = count_t'(pattern_length);
        if (len_wide > count_t'(PATTERN_MAX))
        begin
            len_eff = count_t'(PATTERN_MAX);
        end
        else
        begin
            len_eff = len_wide;
        end
    end

    // Window entry j pairs with pattern byte len-1-j; lanes past len pass
    always_comb
    begin
        pos = '0;
        for (int j = 0; j < PATTERN_MAX; j++)
        begin
            pos = len_eff - count_t'(j) - count_t'(1);
            if (count_t'(j) < len_eff)
            begin
                lane_ok[j] = (window[j] == pattern[pos[IDX_W-1:0]]);
            end
            else
            begin
                lane_ok[j] = 1'b1;
            end
        end
    end

    // Zero length never matches; need enough bytes of this file
    assign match = (len_eff != '0) && (bytes_seen >= len_eff) && (&lane_ok);

endmodule

// File: sv/case_folded_substring_search_unit.sv
// ----------------------------------------------------------------------------
// case_folded_substring_search_unit
// Path: an accepted byte is registered in the window stage, then in the result register.
// Throughput: one byte per cycle; the window stage and result register move
// together and stall only while a result waits downstream.
// Reset: clears found flag, byte count, valids; pattern zero, length one.
// ----------------------------------------------------------------------------
module case_folded_substring_search_unit
    import csss_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // Byte channel
    input  logic                 byte_valid,
    output logic                 byte_stall,
    input  byte_item_t           byte_item,
    // Result channel
    output logic                 result_valid,
    input  logic                 result_stall,
    output verdict_t             verdict,
    // Configuration channel
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  word_t                cfg_data
);

    window_t              pattern;
    logic [LEN_REG_W-1:0] pattern_length;
    window_t              window;
    count_t               bytes_seen;
    stage_t               stage;
    logic                 match;
    logic                 advance;
    logic                 take;

    logic                 found_reg;
    logic                 found_next;
    logic                 result_valid_reg;
    logic                 result_valid_next;
    verdict_t             verdict_reg;
    verdict_t             verdict_next;

    assign cfg_ready = 1'b1;

    // Pipeline moves unless a result is held up
    assign advance    = !(result_valid_reg && result_stall);
    assign byte_stall = !advance;
    assign take       = byte_valid && advance;

    csss_cfg u_cfg (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .pattern        (pattern),
        .pattern_length (pattern_length)
    );

    csss_window u_window (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .take       (take),
        .item       (byte_item),
        .window     (window),
        .bytes_seen (bytes_seen),
        .stage      (stage)
    );

    csss_match u_match (
        .window         (window),
        .pattern        (pattern),
        .pattern_length (pattern_length),
        .bytes_seen     (bytes_seen),
        .match          (match)
    );

    // Sticky flag, cleared by a new file, and the result register
    always_comb
    begin
        found_next        = found_reg;
        result_valid_next = result_valid_reg;
        verdict_next      = verdict_reg;
        if (advance)
        begin
            result_valid_next = stage.valid;
            if (stage.valid)
            begin
                found_next = (found_reg && !stage.first_byte) || match;
                verdict_next.found     = found_next;
                verdict_next.file_done = stage.last_byte;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg        <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            found_reg        <= found_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        verdict_reg <= verdict_next;
    end

    assign result_valid = result_valid_reg;
    assign verdict      = verdict_reg;

endmodule

// File: tb/sv/case_folded_substring_search_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// case_folded_substring_search_unit_tb
// Streams files of bytes through the search unit and checks every result
// transfer against a cycle-free model of the folded sliding-window match.
// A short directed run covers the folding boundaries, file start and end
// markers and bytes after the end marker. Random files follow, seeded with
// whole and broken copies of the pattern, under several pattern settings
// and three idling regimes.
// ----------------------------------------------------------------------------
module case_folded_substring_search_unit_tb;
    import csss_pkg::*;

    // Pattern content styles for the random phases
    typedef enum int { PAT_LETTERS, PAT_RANDOM, PAT_ALL_ONES } pat_style_t;

    // ------------------------------------------------------------------------
    // Scoreboard: folded window model and queue of awaited results
    // ------------------------------------------------------------------------
    class search_scoreboard;
        byte_t          pat [REG_BYTES];
        logic [5:0]     len_reg;
        byte_t          win [PATTERN_MAX];
        int             seen;
        logic           found_flag;
        verdict_t       awaited [$];
        int             errors;

        function new();
            foreach (pat[k])
            begin
                pat[k] = '0;
            end
            foreach (win[k])
            begin
                win[k] = '0;
            end
            len_reg    = 6'd1;
            seen       = 0;
            found_flag = 1'b0;
            errors     = 0;
        endfunction

        static function byte_t fold_char(byte_t b);
            if ((b >= 8'h41) && (b <= 8'h5A))
            begin
                return b + 8'h20;
            end
            return b;
        endfunction

        // Register write as seen at an accepted configuration transfer
        function void write_reg(logic [CFG_IDX_W-1:0] idx, word_t d);
            case (idx)
                CFG_PAT_LO, CFG_PAT_MID_LO, CFG_PAT_MID_HI, CFG_PAT_HI:
                begin
                    for (int b = 0; b < WORD_BYTES; b++)
                    begin
                        pat[idx * WORD_BYTES + b] = d[b*8 +: 8];
                    end
                end
                CFG_PAT_LEN:
                begin
                    len_reg = d[5:0];
                end
                default:
                begin
                    // beyond the register list: ignored
                end
            endcase
        endfunction

        // Accepted byte transfer: shift window, update flag, queue the result
        function void take_byte(byte_item_t it);
            int           eff;
            logic         hit;
            verdict_t     r;
            if (it.first_byte)
            begin
                seen       = 0;
                found_flag = 1'b0;
            end
            for (int i = PATTERN_MAX - 1; i > 0; i--)
            begin
                win[i] = win[i-1];
            end
            win[0] = fold_char(it.data_byte);
            if (seen < PATTERN_MAX)
            begin
                seen++;
            end
            eff = (len_reg > PATTERN_MAX) ? PATTERN_MAX : int'(len_reg);
            if ((eff > 0) && (seen >= eff))
            begin
                hit = 1'b1;
                for (int k = 0; k < eff; k++)
                begin
                    if (win[eff - 1 - k] != fold_char(pat[k]))
                    begin
                        hit = 1'b0;
                    end
                end
                if (hit)
                begin
                    found_flag = 1'b1;
                end
            end
            r.found     = found_flag;
            r.file_done = it.last_byte;
            awaited.push_back(r);
        endfunction

        // Accepted result transfer against the oldest awaited one
        function void check_result(verdict_t got);
            verdict_t want;
            if (awaited.size() == 0)
            begin
                $error("result with none awaited: found %0b file_done %0b",
                       got.found, got.file_done);
                errors++;
                return;
            end
            want = awaited.pop_front();
            if (got.found !== want.found)
            begin
                $error("found: expected %0b, actual %0b", want.found, got.found);
                errors++;
            end
            if (got.file_done !== want.file_done)
            begin
                $error("file_done: expected %0b, actual %0b",
                       want.file_done, got.file_done);
                errors++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals and instance
    // ------------------------------------------------------------------------
    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 byte_valid;
    logic                 byte_stall;
    byte_item_t           byte_item;
    logic                 result_valid;
    logic                 result_stall = 1'b0;
    verdict_t             verdict;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    word_t                cfg_data;

    search_scoreboard     sb;
    int                   send_idle = 36;
    int                   recv_idle = 58;
    int                   bytes_sent = 0;

    case_folded_substring_search_unit uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_stall   (byte_stall),
        .byte_item    (byte_item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .verdict      (verdict),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // Clock, 10 ns period
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Receiver back-pressure
    always @(negedge clk)
    begin
        result_stall = ($urandom_range(99) < recv_idle);
    end

    // Transfer monitor; result checked before the byte of the same edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid && !result_stall)
            begin
                sb.check_result(verdict);
            end
            if (byte_valid && !byte_stall)
            begin
                sb.take_byte(byte_item);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Driver tasks
    // ------------------------------------------------------------------------
    function automatic byte_t flip_case(byte_t b);
        if ((((b >= 8'h41) && (b <= 8'h5A)) || ((b >= 8'h61) && (b <= 8'h7A)))
            && ($urandom_range(1) == 1))
        begin
            return b ^ 8'h20;
        end
        return b;
    endfunction

    // One byte transfer; entered and left at a falling edge
    task automatic send_byte(input byte_t data, input logic first, input logic last);
        while ($urandom_range(99) < send_idle)
        begin
            byte_valid = 1'b0;
            @(negedge clk);
        end
        byte_item  = '{last_byte: last, first_byte: first, data_byte: data};
        byte_valid = 1'b1;
        do @(posedge clk); while (byte_stall);
        @(negedge clk);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input word_t data);
        cfg_index = idx;
        cfg_data  = data;
        cfg_valid = 1'b1;
        do @(posedge clk); while (!cfg_ready);
        sb.write_reg(idx, data);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Drain all awaited results plus the pipeline depth
    task automatic wait_idle();
        byte_valid = 1'b0;
        while (sb.awaited.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic load_pattern(input pat_style_t style, input logic [5:0] len);
        cfg_index_t word_reg [CFG_WORDS] = '{CFG_PAT_LO, CFG_PAT_MID_LO,
                                             CFG_PAT_MID_HI, CFG_PAT_HI};
        word_t      w;
        byte_t      b;
        for (int wi = 0; wi < CFG_WORDS; wi++)
        begin
            for (int bi = 0; bi < WORD_BYTES; bi++)
            begin
                case (style)
                    PAT_LETTERS:  b = flip_case(8'h41 + 8'($urandom_range(25)));
                    PAT_RANDOM:   b = 8'($urandom_range(255));
                    default:      b = 8'hFF;
                endcase
                w[bi*8 +: 8] = b;
            end
            write_cfg(word_reg[wi], w);
        end
        // stray write past the register list
        if ($urandom_range(1) == 1)
        begin
            write_cfg(CFG_IDX_W'(CFG_PAT_LEN + $urandom_range(1, 3)), {$urandom, $urandom});
        end
        w      = {$urandom, $urandom};
        w[5:0] = len;
        write_cfg(CFG_PAT_LEN, w);
    endtask

    // One file built from whole and broken pattern copies and noise
    task automatic send_file();
        byte_t stream [$];
        int    eff;
        int    plant_len;
        int    target;
        int    pick;
        int    cut;
        logic  mark_first;
        logic  end_mark;
        eff        = (sb.len_reg > PATTERN_MAX) ? PATTERN_MAX : int'(sb.len_reg);
        plant_len  = (eff == 0) ? 4 : eff;
        target     = ($urandom_range(9) == 0) ? 1 : $urandom_range(1, 2 * plant_len + 24);
        mark_first = ($urandom_range(9) != 0);
        end_mark   = ($urandom_range(9) != 0);
        while (stream.size() < target)
        begin
            pick = $urandom_range(99);
            if (pick < 30)
            begin
                for (int k = 0; k < plant_len; k++)
                begin
                    stream.push_back(flip_case(sb.pat[k]));
                end
            end
            else if (pick < 45)
            begin
                cut = $urandom_range(plant_len - 1);
                for (int k = 0; k < cut; k++)
                begin
                    stream.push_back(flip_case(sb.pat[k]));
                end
                stream.push_back(8'($urandom_range(255)));
            end
            else if (pick < 85)
            begin
                stream.push_back(flip_case(sb.pat[$urandom_range(plant_len - 1)]));
            end
            else
            begin
                stream.push_back(8'($urandom_range(255)));
            end
        end
        foreach (stream[k])
        begin
            send_byte(stream[k], mark_first && (k == 0),
                      (k == stream.size() - 1) ? end_mark : ($urandom_range(49) == 0));
        end
        bytes_sent += stream.size();
    endtask

    task automatic run_phase(input pat_style_t style, input logic [5:0] len,
                             input int count);
        int goal;
        wait_idle();
        load_pattern(style, len);
        goal = bytes_sent + count;
        while (bytes_sent < goal)
        begin
            send_file();
        end
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin
        sb         = new();
        rst_n      = 1'b0;
        byte_valid = 1'b0;
        byte_item  = '0;
        cfg_valid  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: pattern "Z@A", letters at both ends of the range
        write_cfg(CFG_PAT_LO, 64'h0000_0000_0041_405A);
        write_cfg(CFG_PAT_LEN, 64'd3);
        send_byte(8'h00, 1'b1, 1'b0);
        send_byte(8'hFF, 1'b0, 1'b0);
        send_byte(8'h7A, 1'b0, 1'b0);
        send_byte(8'h60, 1'b0, 1'b0);   // backtick must not fold to '@'
        send_byte(8'h41, 1'b0, 1'b0);
        send_byte(8'h7A, 1'b0, 1'b0);
        send_byte(8'h40, 1'b0, 1'b0);
        send_byte(8'h61, 1'b0, 1'b0);   // match ends here
        send_byte(8'h5B, 1'b0, 1'b1);
        send_byte(8'h20, 1'b0, 1'b0);   // past the end marker, same file
        send_byte(8'h5A, 1'b1, 1'b0);
        send_byte(8'h40, 1'b0, 1'b0);
        send_byte(8'h41, 1'b0, 1'b1);
        send_byte(8'h00, 1'b1, 1'b1);   // one-byte file, flag cleared
        // Directed: single-byte pattern 'Q'
        wait_idle();
        write_cfg(CFG_PAT_LO, 64'h0000_0000_0000_0051);
        write_cfg(CFG_PAT_LEN, 64'd1);
        send_byte(8'h71, 1'b1, 1'b1);
        send_byte(8'h5B, 1'b1, 1'b0);
        send_byte(8'h51, 1'b0, 1'b1);
        send_byte(8'h40, 1'b1, 1'b1);

        // Random: sender idles less than receiver
        run_phase(PAT_LETTERS, 6'($urandom_range(2, 6)), 110);
        run_phase(PAT_RANDOM, 6'd32, 110);
        // Random: receiver idles less than sender
        send_idle = 58;
        recv_idle = 36;
        run_phase(PAT_LETTERS, 6'd1, 110);
        run_phase(PAT_LETTERS, 6'd0, 110);     // zero length never matches
        run_phase(PAT_ALL_ONES, 6'd63, 110);   // oversize length clamps
        // Random: no idling
        send_idle = 0;
        recv_idle = 0;
        run_phase(PAT_RANDOM, 6'($urandom_range(1, 12)), 110);
        run_phase(PAT_LETTERS, 6'd32, 110);

        wait_idle();
        if (sb.errors == 0)
        begin
            $display("[case_folded_substring_search_unit] OK");
        end
        else
        begin
            $display("[case_folded_substring_search_unit] ERROR");
        end
        $finish;
    end

    // Watchdog
    initial
    begin
        #2_000_000;
        $display("[case_folded_substring_search_unit] ERROR");
        $finish;
    end

endmodule
